@@ rtl/xpmdec_pkg.sv @@
// Package for the XPM image decoder: phase codes, register indexes,
// character constants and the structs that travel along the palette cell chain.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xpmdec_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PALETTE,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  localparam int CFG_W = 12;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_STRIDE = 2'd2;
  localparam logic [CFG_W-1:0] STRIDE_RESET = 12'd640;

  localparam logic RESULT_PIXEL = 1'b0;
  localparam logic RESULT_DONE = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_N = 8'h4E;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;

  // Column positions inside a palette string.
  localparam int COL_KEY = 0;
  localparam int COL_CLEAR = 4;
  localparam int COL_HEX_FIRST = 5;
  localparam int COL_HEX_LAST = 10;

  localparam int PCOUNT_W = 9;
  localparam int HEADER_FIELDS = 3;
  localparam int FIELD_WIDTH = 0;
  localparam int FIELD_HEIGHT = 1;
  localparam int FIELD_COLOURS = 2;

  typedef struct packed {
    logic [7:0]  key;
    logic        transp;
    logic [23:0] colour;
  } pal_entry_t;

  typedef struct packed {
    logic        valid;
    logic        done;
    logic [7:0]  ch;
    logic        hit;
    logic        transp;
    logic [23:0] colour;
  } tok_t;

  // Value of one hex digit; anything but A..F counts as its code minus '0'.
  function automatic logic [23:0] hex_digit(input logic [7:0] c);
    logic [23:0] d;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = 24'(c) - 24'(CH_UPPER_A) + 24'd10;
    end else begin
      d = 24'(c) - 24'(CH_ZERO);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/xpmdec_cell.sv @@
// One cell of the palette chain: holds one palette entry and one request slot.
// Depends on xpmdec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xpmdec_cell import xpmdec_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int ROW_W = 13,
  parameter int LIVE_W = 9
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic              shift,
  input  wire pal_entry_t        ent_in,
  output pal_entry_t             ent_out,
  input  wire tok_t              tok_in,
  input  wire logic [COORD_BITS-1:0] col_in,
  input  wire logic [ROW_W-1:0]  row_in,
  input  wire logic [LIVE_W-1:0] live_in,
  output tok_t                   tok_out,
  output logic [COORD_BITS-1:0]  col_out,
  output logic [ROW_W-1:0]       row_out,
  output logic [LIVE_W-1:0]      live_out
);

  pal_entry_t ent;
  tok_t tok_next;
  logic [LIVE_W-1:0] live_next;
  logic match;

  // Entries shift in from the head; the oldest sits furthest down the chain.
  always_ff @(posedge clk) begin
    if (shift) begin
      ent <= ent_in;
    end
  end

  assign ent_out = ent;

  // Later cells hold older entries, so a later hit overrides an earlier one.
  always_comb begin
    match = tok_in.valid && !tok_in.done && (live_in != '0) && (ent.key == tok_in.ch);
    tok_next = tok_in;
    if (match) begin
      tok_next.hit = 1'b1;
      tok_next.transp = ent.transp;
      tok_next.colour = ent.colour;
    end
    live_next = (live_in != '0) ? live_in - LIVE_W'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_out <= col_in;
      row_out <= row_in;
      live_out <= live_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/xpmdec_parse.sv @@
// Stream parser of the XPM decoder: header numbers, palette lines, pixel rows.
// Issues palette writes and search requests into the cell chain. Depends on xpmdec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xpmdec_parse import xpmdec_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int PALETTE_ENTRIES = 256,
  parameter int ROW_W = 13,
  parameter int LIVE_W = 9
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [7:0]            char_code,
  input  wire logic                  end_of_string,
  output tok_t                       tok,
  output logic [COORD_BITS-1:0]      col,
  output logic [ROW_W-1:0]           row,
  output logic [LIVE_W-1:0]          live,
  output logic                       pal_we,
  output pal_entry_t                 pal_ent,
  output logic [COORD_BITS-1:0]      width,
  output logic [COORD_BITS-1:0]      height
);

  localparam int AW = COORD_BITS + 6;
  localparam logic [COORD_BITS-1:0] COORD_MAX = COORD_BITS'((1 << COORD_BITS) - 1);
  localparam logic [AW-1:0] COORD_MAX_W = AW'((1 << COORD_BITS) - 1);

  phase_t phase, phase_next;
  logic [COORD_BITS-1:0] column_count, column_count_next;
  logic [1:0] header_field, header_field_next;
  logic [COORD_BITS-1:0] number_accum, number_accum_next;
  logic [COORD_BITS-1:0] parsed_width, parsed_width_next;
  logic [COORD_BITS-1:0] parsed_height, parsed_height_next;
  logic [PCOUNT_W-1:0] palette_count, palette_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [7:0] entry_key, entry_key_next;
  logic entry_clear, entry_clear_next;
  logic [23:0] hex_accum, hex_accum_next;
  logic [LIVE_W-1:0] fill_count, fill_count_next;

  logic [AW-1:0] num_sum;
  logic [COORD_BITS-1:0] num_clamped;
  logic [COORD_BITS-1:0] commit_width, commit_height;
  logic [PCOUNT_W-1:0] commit_pcount, capped_pcount;
  logic [ROW_W-1:0] row_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      header_field <= '0;
      number_accum <= '0;
      parsed_width <= '0;
      parsed_height <= '0;
      palette_count <= '0;
      row_count <= '0;
      entry_key <= '0;
      entry_clear <= 1'b0;
      hex_accum <= '0;
      fill_count <= '0;
    end else begin
      column_count <= column_count_next;
      header_field <= header_field_next;
      number_accum <= number_accum_next;
      parsed_width <= parsed_width_next;
      parsed_height <= parsed_height_next;
      palette_count <= palette_count_next;
      row_count <= row_count_next;
      entry_key <= entry_key_next;
      entry_clear <= entry_clear_next;
      hex_accum <= hex_accum_next;
      fill_count <= fill_count_next;
    end
  end

  // Decimal accumulation, clamped to the coordinate range on both sides.
  always_comb begin
    num_sum = AW'(number_accum) * AW'(10) + AW'(char_code) - AW'(CH_ZERO);
    if (num_sum[AW-1]) begin
      num_clamped = '0;
    end else if (num_sum > COORD_MAX_W) begin
      num_clamped = COORD_MAX;
    end else begin
      num_clamped = num_sum[COORD_BITS-1:0];
    end
    capped_pcount = ((COORD_BITS + 1)'(number_accum) > (COORD_BITS + 1)'(PALETTE_ENTRIES)) ?
                    PCOUNT_W'(PALETTE_ENTRIES) : PCOUNT_W'(number_accum);
    commit_width = (header_field == 2'(FIELD_WIDTH)) ? number_accum : parsed_width;
    commit_height = (header_field == 2'(FIELD_HEIGHT)) ? number_accum : parsed_height;
    commit_pcount = (header_field == 2'(FIELD_COLOURS)) ? capped_pcount : palette_count;
    row_inc = row_count + ROW_W'(1);
  end

  always_comb begin
    phase_next = phase;
    column_count_next = column_count;
    header_field_next = header_field;
    number_accum_next = number_accum;
    parsed_width_next = parsed_width;
    parsed_height_next = parsed_height;
    palette_count_next = palette_count;
    row_count_next = row_count;
    entry_key_next = entry_key;
    entry_clear_next = entry_clear;
    hex_accum_next = hex_accum;
    fill_count_next = fill_count;
    tok = '0;
    tok.ch = char_code;
    pal_we = 1'b0;
    pal_ent.key = entry_key;
    pal_ent.transp = entry_clear;
    pal_ent.colour = entry_clear ? '0 : hex_accum;

    if (accept && phase != PH_DONE) begin
      if (!end_of_string && column_count < COORD_MAX) begin
        column_count_next = column_count + COORD_BITS'(1);
      end
      case (phase)
        PH_HEADER: begin
          if (end_of_string) begin
            parsed_width_next = commit_width;
            parsed_height_next = commit_height;
            palette_count_next = commit_pcount;
            column_count_next = '0;
            row_count_next = '0;
            entry_key_next = '0;
            entry_clear_next = 1'b0;
            hex_accum_next = '0;
            if (commit_pcount == '0) begin
              phase_next = PH_PIXELS;
              if (commit_height == '0) begin
                tok.valid = 1'b1;
                tok.done = 1'b1;
                phase_next = PH_DONE;
              end
            end else begin
              phase_next = PH_PALETTE;
            end
          end else if (header_field < 2'(HEADER_FIELDS)) begin
            if (char_code == CH_SPACE) begin
              parsed_width_next = commit_width;
              parsed_height_next = commit_height;
              palette_count_next = commit_pcount;
              header_field_next = header_field + 2'd1;
              number_accum_next = '0;
            end else begin
              number_accum_next = num_clamped;
            end
          end
        end
        PH_PALETTE: begin
          if (end_of_string) begin
            if (row_count < ROW_W'(PALETTE_ENTRIES)) begin
              pal_we = 1'b1;
              fill_count_next = fill_count + LIVE_W'(1);
            end
            row_count_next = row_inc;
            column_count_next = '0;
            entry_key_next = '0;
            entry_clear_next = 1'b0;
            hex_accum_next = '0;
            if (row_inc >= ROW_W'(palette_count)) begin
              phase_next = PH_PIXELS;
              row_count_next = '0;
              if (parsed_height == '0) begin
                tok.valid = 1'b1;
                tok.done = 1'b1;
                phase_next = PH_DONE;
              end
            end
          end else if (column_count == COORD_BITS'(COL_KEY)) begin
            entry_key_next = char_code;
          end else if (column_count == COORD_BITS'(COL_CLEAR)) begin
            entry_clear_next = (char_code == CH_UPPER_N) || (char_code == CH_LOWER_N);
          end else if (column_count >= COORD_BITS'(COL_HEX_FIRST) &&
                       column_count <= COORD_BITS'(COL_HEX_LAST)) begin
            hex_accum_next = {hex_accum[19:0], 4'h0} + hex_digit(char_code);
          end
        end
        PH_PIXELS: begin
          if (end_of_string) begin
            column_count_next = '0;
            row_count_next = row_inc;
            if (row_inc >= ROW_W'(parsed_height)) begin
              tok.valid = 1'b1;
              tok.done = 1'b1;
              phase_next = PH_DONE;
            end
          end else if (column_count < parsed_width) begin
            tok.valid = 1'b1;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  assign col = column_count;
  assign row = row_count;
  assign live = fill_count;
  assign width = parsed_width;
  assign height = parsed_height;

endmodule

`default_nettype wire

@@ rtl/xpm_image_decoder.sv @@
// XPM image decoder top level: parser, palette cell chain and result register.
// Depends on xpmdec_pkg, xpmdec_parse and xpmdec_cell.
//
// Usage: characters of the XPM strings arrive on the input channel
// (in_valid / in_stall), one request per character, or one request with
// end_of_string set to close a string. Results leave on the output channel
// (out_valid / out_stall): a pixel write for each opaque pixel whose
// character matches a palette key, and a single done result after the last
// pixel row, carrying the parsed width and height.
// Every accepted request sends a slot down a chain of PALETTE_ENTRIES cells,
// one cell per entry; each cell compares the slot's character with its own
// key. The chain moves unless a waiting result is stalled, so one request
// is accepted per clock while it moves; a result passes each cell register
// and then the result register, so its delay grows with the chain length.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_stall is raised until the result is taken. Reset clears the parser to
// the header phase and empties the chain; the palette itself is not cleared,
// a fill count limits which cells take part. Configuration writes (cfg_we,
// cfg_index, cfg_data) must be made while idle; the block does not check this.
`timescale 1ns / 1ps
`default_nettype none

module xpm_image_decoder import xpmdec_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int COORD_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             char_code,
  input  wire logic                   end_of_string,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        result_kind,
  output logic [12:0]                 pixel_x,
  output logic [12:0]                 pixel_y,
  output logic [25:0]                 pixel_offset,
  output logic [23:0]                 pixel_colour,
  output logic [11:0]                 image_width,
  output logic [11:0]                 image_height
);

  localparam int ROW_W = COORD_BITS + 1;
  localparam int LIVE_W = $clog2(PALETTE_ENTRIES + 1);
  // Wide enough for a coordinate or row plus a 12-bit origin.
  localparam int CW = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 1;
  localparam int PW = CW + CFG_W;

  logic [CFG_W-1:0] origin_x, origin_y, line_stride;
  logic adv, accept;

  tok_t head_tok;
  logic [COORD_BITS-1:0] head_col;
  logic [ROW_W-1:0] head_row;
  logic [LIVE_W-1:0] head_live;
  logic pal_we;
  pal_entry_t pal_ent;
  logic [COORD_BITS-1:0] parsed_width, parsed_height;

  tok_t tok_q [0:PALETTE_ENTRIES];
  logic [COORD_BITS-1:0] col_q [0:PALETTE_ENTRIES];
  logic [ROW_W-1:0] row_q [0:PALETTE_ENTRIES];
  logic [LIVE_W-1:0] live_q [0:PALETTE_ENTRIES];
  pal_entry_t ent_q [0:PALETTE_ENTRIES];

  tok_t tail;
  logic emit;
  logic [CW-1:0] px, py;
  logic [PW-1:0] prod;
  logic [25:0] offset;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      line_stride <= STRIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_LINE_STRIDE: line_stride <= cfg_data;
        default: origin_x <= origin_x;
      endcase
    end
  end

  // The chain and the result register move together; a waiting result that
  // is stalled freezes everything behind it.
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept = in_valid && adv;

  xpmdec_parse #(
    .COORD_BITS(COORD_BITS),
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .ROW_W(ROW_W),
    .LIVE_W(LIVE_W)
  ) u_parse (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .char_code(char_code),
    .end_of_string(end_of_string),
    .tok(head_tok),
    .col(head_col),
    .row(head_row),
    .live(head_live),
    .pal_we(pal_we),
    .pal_ent(pal_ent),
    .width(parsed_width),
    .height(parsed_height)
  );

  assign tok_q[0] = head_tok;
  assign col_q[0] = head_col;
  assign row_q[0] = head_row;
  assign live_q[0] = head_live;
  assign ent_q[0] = pal_ent;

  // Cell i hands its request slot and, on a palette write, its entry to i+1.
  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    xpmdec_cell #(
      .COORD_BITS(COORD_BITS),
      .ROW_W(ROW_W),
      .LIVE_W(LIVE_W)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .adv(adv),
      .shift(pal_we),
      .ent_in(ent_q[i]),
      .ent_out(ent_q[i+1]),
      .tok_in(tok_q[i]),
      .col_in(col_q[i]),
      .row_in(row_q[i]),
      .live_in(live_q[i]),
      .tok_out(tok_q[i+1]),
      .col_out(col_q[i+1]),
      .row_out(row_q[i+1]),
      .live_out(live_q[i+1])
    );
  end

  // A slot leaving the chain becomes a result if it is the done marker or an
  // opaque hit; transparent and unmatched pixels are dropped here.
  always_comb begin
    tail = tok_q[PALETTE_ENTRIES];
    emit = tail.valid && (tail.done || (tail.hit && !tail.transp));
    px = CW'(col_q[PALETTE_ENTRIES]) + CW'(origin_x);
    py = CW'(row_q[PALETTE_ENTRIES]) + CW'(origin_y);
    prod = PW'(line_stride) * PW'(py);
    offset = 26'(prod) + 26'(px);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (tail.done) begin
        result_kind <= RESULT_DONE;
        pixel_x <= '0;
        pixel_y <= '0;
        pixel_offset <= '0;
        pixel_colour <= '0;
        image_width <= 12'(parsed_width);
        image_height <= 12'(parsed_height);
      end else begin
        result_kind <= RESULT_PIXEL;
        pixel_x <= 13'(px);
        pixel_y <= 13'(py);
        pixel_offset <= offset;
        pixel_colour <= tail.colour;
        image_width <= '0;
        image_height <= '0;
      end
    end
  end

  // The done result is the last one the block ever produces.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && result_kind == RESULT_DONE |=> !out_valid)
    else $error("result after done");

  // Input is only held off while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // A transparent or unmatched pixel never leaves as a pixel write.
  a_pixel_hit: assert property (@(posedge clk) disable iff (rst)
    adv && tail.valid && !tail.done && !(tail.hit && !tail.transp) |=> !out_valid)
    else $error("unmatched pixel emitted");

endmodule

`default_nettype wire
